FILE: rtl/core/serk_pkg.sv
// ----------------------------------------------------------------------------
// serk_pkg: shared types and constants
// Fixed point format, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package serk_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int COUNT_BITS = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_PARAM_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_U    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_V    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 3'd5;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = -32'sh7fffffff - 32'sh1;

  // clamp a 36 bit sum into the signed 32 bit range
  function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'(SAT_MAX);
    lo = 36'(SAT_MIN);
    if (x > hi) begin
      sat36 = SAT_MAX;
    end else if (x < lo) begin
      sat36 = SAT_MIN;
    end else begin
      sat36 = x[31:0];
    end
  endfunction

endpackage

FILE: rtl/core/serk_mul.sv
// ----------------------------------------------------------------------------
// serk_mul: shared fixed point multiplier
// Registered 32x32 product with rounding, floor shift and saturation.
// ----------------------------------------------------------------------------
module serk_mul import serk_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  output logic signed [31:0] p
);

  logic signed [63:0] prod;
  logic signed [63:0] shifted;
  logic signed [63:0] hi;
  logic signed [63:0] lo;

  // product registered, rounding and saturation on the following cycle
  always_ff @(posedge clk) begin
    prod <= 64'(x) * 64'(y);
  end

  always_comb begin
    shifted = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    hi = 64'(SAT_MAX);
    lo = 64'(SAT_MIN);
    if (shifted > hi) begin
      p = SAT_MAX;
    end else if (shifted < lo) begin
      p = SAT_MIN;
    end else begin
      p = shifted[31:0];
    end
  end

endmodule

FILE: rtl/core/schnakenberg_euler_rk4_step.sv
// ----------------------------------------------------------------------------
// schnakenberg_euler_rk4_step: Euler and RK4 step of a reaction system
// Timing: a restart or halted request offers its result in the cycle after it
// is taken; a step request runs 20 multiplies through one shared registered
// multiplier, then 5 stage updates, 4 turnaround states, a divide and a
// commit. Throughput: one request at a time; the next is taken only after
// the result has been accepted (out_stall low).
// Reset: synchronous, restores register defaults and reloads start values.
// ----------------------------------------------------------------------------
module schnakenberg_euler_rk4_step import serk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [19:0]           step_index,
  output logic signed [31:0]    euler_u,
  output logic signed [31:0]    euler_v,
  output logic signed [31:0]    rk_u,
  output logic signed [31:0]    rk_v,
  output logic                  euler_fault,
  output logic                  rk_fault,
  output logic                  run_over
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_MA, S_MB, S_MC, S_MD, S_MK, S_NEXT, S_DIV, S_DONE, S_OUT
  } state_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_t state;
  logic [30:0] param_a, param_b, start_u, start_v;
  logic [24:0] time_step;
  logic [19:0] run_length;
  logic signed [31:0] eu, ev, ru, rv;
  logic [COUNT_BITS-1:0] cnt;
  logic halted;

  // evaluation bookkeeping: eval 0 euler, 1..4 rk stages
  logic [2:0] eval;
  logic signed [31:0] pu, pv, uu, uuv, ku, kv;
  logic signed [35:0] su, sv;
  logic signed [35:0] qu, qv;
  logic signed [31:0] mx, my, mp;
  logic [1:0] wait_cnt;
  logic signed [31:0] half_ku, half_kv;
  logic signed [35:0] fu, fv;

  serk_mul u_mul (.clk(clk), .x(mx), .y(my), .p(mp));

  assign in_stall = (state != S_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_MA:    begin mx = pu;  my = pu; end
      S_MB:    begin mx = uu;  my = pv; end
      S_MC:    begin mx = 32'(time_step); my = 32'(sat36(fu)); end
      S_MD:    begin mx = 32'(time_step); my = 32'(sat36(fv)); end
      default: begin mx = pu;  my = pv; end
    endcase
  end

  assign fu = 36'(signed'({1'b0, param_a})) - 36'(pu) + 36'(uuv);
  assign fv = 36'(signed'({1'b0, param_b})) - 36'(uuv);
  assign half_ku = sat36((36'(ku) + 36'sd1) >>> 1);
  assign half_kv = sat36((36'(kv) + 36'sd1) >>> 1);

  // floor((s+3)/6): bias to non-negative, halve, then divide by 3 using
  // 2^18 = 3 * 87381 + 1 on the high and low parts
  function automatic logic signed [35:0] div6(input logic signed [35:0] s);
    logic [35:0] m;
    logic [34:0] h;
    logic [18:0] t;
    logic [38:0] tq;
    logic [35:0] q;
    m  = 36'(37'(s) + 37'sd3 + 37'sd25769803776);
    h  = m[35:1];
    t  = 19'(h[34:18]) + 19'(h[17:0]);
    tq = 39'(t) * 39'd349526;
    q  = 36'(h[34:18]) * 36'd87381 + 36'(tq[38:20]);
    div6 = signed'(q) - 36'sd4294967296;
  endfunction

  logic signed [31:0] nu, nv;
  assign nu = sat36(36'(ru) + qu);
  assign nv = sat36(36'(rv) + qv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      param_a <= 31'd1677722; param_b <= 31'd6710886; time_step <= 25'd16777;
      start_u <= 31'd16777216; start_v <= 31'd16777216; run_length <= 20'd100000;
      eu <= 32'sd16777216; ev <= 32'sd16777216;
      ru <= 32'sd16777216; rv <= 32'sd16777216;
      cnt <= '0; halted <= 1'b0; eval <= '0; wait_cnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PARAM_A:    param_a <= cfg_data;
          REG_PARAM_B:    param_b <= cfg_data;
          REG_TIME_STEP:  time_step <= cfg_data[24:0];
          REG_START_U:    start_u <= cfg_data;
          REG_START_V:    start_v <= cfg_data;
          REG_RUN_LENGTH: run_length <= cfg_data[19:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            euler_fault <= 1'b0; rk_fault <= 1'b0;
            if (restart) begin
              eu <= 32'(start_u); ev <= 32'(start_v);
              ru <= 32'(start_u); rv <= 32'(start_v);
              cnt <= '0; halted <= 1'b0;
              step_index <= '0;
              euler_u <= 32'(start_u); euler_v <= 32'(start_v);
              rk_u <= 32'(start_u); rk_v <= 32'(start_v);
              run_over <= 1'b0; state <= S_OUT; out_valid <= 1'b1;
            end else begin
              step_index <= 20'(cnt);
              euler_u <= eu; euler_v <= ev; rk_u <= ru; rk_v <= rv;
              if (halted) begin
                run_over <= 1'b1; state <= S_OUT; out_valid <= 1'b1;
              end else begin
                eval <= 3'd0; pu <= eu; pv <= ev;
                su <= '0; sv <= '0; state <= S_MA; wait_cnt <= '0;
              end
            end
          end
        end
        S_MA, S_MB, S_MC, S_MD: begin
          // wait on the registered multiplier product before capturing it
          if (wait_cnt == 2'd2) begin
            wait_cnt <= '0;
            unique case (state)
              S_MA: begin uu <= mp; state <= S_MB; end
              S_MB: begin uuv <= mp; state <= S_MC; end
              S_MC: begin ku <= mp; state <= S_MD; end
              default: begin kv <= mp; state <= S_MK; end
            endcase
          end else begin
            wait_cnt <= wait_cnt + 2'd1;
          end
        end
        S_MK: begin
          // update the Euler state or accumulate weighted k terms, and form the next stage point
          if (eval == 3'd0) begin
            eu <= sat36(36'(eu) + 36'(ku));
            ev <= sat36(36'(ev) + 36'(kv));
            pu <= ru; pv <= rv;
          end else begin
            if (eval == 3'd1 || eval == 3'd4) begin
              su <= su + 36'(ku); sv <= sv + 36'(kv);
            end else begin
              su <= su + (36'(ku) <<< 1); sv <= sv + (36'(kv) <<< 1);
            end
            if (eval == 3'd3) begin
              pu <= sat36(36'(ru) + 36'(ku)); pv <= sat36(36'(rv) + 36'(kv));
            end else begin
              pu <= sat36(36'(ru) + 36'(half_ku));
              pv <= sat36(36'(rv) + 36'(half_kv));
            end
          end
          state <= (eval == 3'd4) ? S_DIV : S_NEXT;
          eval <= eval + 3'd1;
        end
        S_NEXT: state <= S_MA;
        // weighted sums divided by six
        S_DIV: begin
          qu <= div6(su); qv <= div6(sv);
          state <= S_DONE;
        end
        S_DONE: begin
          ru <= nu; rv <= nv;
          euler_fault <= (eu <= 0) || (ev <= 0);
          rk_fault <= (nu <= 0) || (nv <= 0);
          if (cnt != CNT_MAX) cnt <= cnt + 1'b1;
          if ((nu <= 0) || (nv <= 0) || (COUNT_BITS'(cnt + 1'b1) >= COUNT_BITS'(run_length))
              || (cnt + 1'b1 >= CNT_MAX) || (cnt == CNT_MAX)) begin
            halted <= 1'b1; run_over <= 1'b1;
          end else begin
            run_over <= 1'b0;
          end
          state <= S_OUT; out_valid <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepting while result pending");
  a_halt_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && $past(state) == S_IDLE && halted) |-> $stable(ru))
    else $error("state changed while halted");
  a_rkfault_halt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rk_fault) |-> halted) else $error("rk fault without halt");

endmodule
